/* sv/wufph_pkg.sv */
package wufph_pkg;

   localparam int ELEMENTS_DEFAULT = 1024;
   localparam int INDEX_W          = 10;
   localparam int COUNT_W          = 11;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_REJECT,
      CMD_START,
      CMD_ASCEND,
      CMD_HALVE,
      CMD_NEXT_ROOT,
      CMD_ANSWER,
      CMD_SIZE_A,
      CMD_SIZE_B,
      CMD_LINK
   } dp_cmd_type;

   typedef struct packed {
      logic in_range;
      logic at_root;
      logic same_root;
      logic query;
      logic clear_done;
   } dp_status_type;

endpackage

/* sv/weighted_union_find_path_halving.sv */
// Disjoint-set engine: start with busy low takes one union or connectivity
// query; exactly one result word follows on rsp_* with rsp_valid high for a
// single cycle, and it cannot be held off, so capture it when it shows.
// After reset the block sweeps all ELEMENTS entries of the parent and size
// stores, one entry a cycle, with busy high. An item with an index out of
// range is answered in the next cycle and leaves busy low. Any other item
// keeps busy high while it walks from each index to its root, one halving
// step (which moves the walk to the grandparent) at a time, and for a union
// that joins two trees also while it reads both root sizes and links them;
// the single read port of the parent store splits each halving step into a
// read and a repoint. Path halving keeps the walks short.
module weighted_union_find_path_halving #(
   parameter int ELEMENTS = wufph_pkg::ELEMENTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [wufph_pkg::INDEX_W-1:0] req_first_index,
   input  logic [wufph_pkg::INDEX_W-1:0] req_second_index,
   input  logic                          csr_write_enable,
   input  logic [wufph_pkg::COUNT_W-1:0] csr_write_data,
   output logic                          rsp_valid,
   output logic                          rsp_connected,
   output logic                          rsp_index_error
);
   import wufph_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   wufph_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   wufph_datapath #(
      .ELEMENTS (ELEMENTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_connected    (rsp_connected),
      .rsp_index_error  (rsp_index_error)
   );

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result word without an item in flight");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_connected && rsp_index_error))
      else $error("result word flags both connected and index error");

   a_reject_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !status.in_range) |=> (rsp_valid && rsp_index_error && !busy))
      else $error("out-of-range item not answered in the next cycle");

   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && status.in_range) |=> (busy && !rsp_valid))
      else $error("in-range item did not start a root walk");

endmodule

/* sv/wufph_ctrl.sv */
module wufph_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  wufph_pkg::dp_status_type status,
   output wufph_pkg::dp_cmd_type    cmd,
   output logic                     busy
);
   import wufph_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_UP,
      ST_WALK_GP,
      ST_SIZE_A,
      ST_SIZE_B
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;
   logic      busy_ff;

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      cmd       = CMD_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (status.in_range) begin
                  cmd       = CMD_START;
                  second_in = 1'b0;
                  state_in  = ST_WALK_UP;
               end else begin
                  cmd = CMD_REJECT;
               end
            end
         end
         ST_WALK_UP: begin
            if (!status.at_root) begin
               cmd      = CMD_ASCEND;
               state_in = ST_WALK_GP;
            end else if (!second_ff) begin
               cmd       = CMD_NEXT_ROOT;
               second_in = 1'b1;
            end else if (status.query || status.same_root) begin
               cmd      = CMD_ANSWER;
               state_in = ST_IDLE;
            end else begin
               cmd      = CMD_SIZE_A;
               state_in = ST_SIZE_A;
            end
         end
         ST_WALK_GP: begin
            cmd      = CMD_HALVE;
            state_in = ST_WALK_UP;
         end
         ST_SIZE_A: begin
            cmd      = CMD_SIZE_B;
            state_in = ST_SIZE_B;
         end
         ST_SIZE_B: begin
            cmd      = CMD_LINK;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         second_ff <= 1'b0;
         busy_ff   <= 1'b1;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
         busy_ff   <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

/* sv/wufph_datapath.sv */
module wufph_datapath #(
   parameter int ELEMENTS = wufph_pkg::ELEMENTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wufph_pkg::dp_cmd_type          cmd,
   output wufph_pkg::dp_status_type       status,
   input  logic                           req_action,
   input  logic [wufph_pkg::INDEX_W-1:0]  req_first_index,
   input  logic [wufph_pkg::INDEX_W-1:0]  req_second_index,
   input  logic                           csr_write_enable,
   input  logic [wufph_pkg::COUNT_W-1:0]  csr_write_data,
   output logic                           rsp_valid,
   output logic                           rsp_connected,
   output logic                           rsp_index_error
);
   import wufph_pkg::*;

   localparam int NODE_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
   localparam int SIZE_W = $clog2(ELEMENTS + 1);

   logic [NODE_W-1:0] parent_mem [ELEMENTS];
   logic [SIZE_W-1:0] size_mem   [ELEMENTS];

   logic [COUNT_W-1:0] count_ff;
   logic [NODE_W-1:0]  clear_ptr_ff;
   logic [NODE_W-1:0]  node_ff, b_ff, root_a_ff, root_b_ff, par_rd_ff;
   logic [SIZE_W-1:0]  size_a_ff, size_rd_ff;
   logic               query_ff;
   logic               rsp_valid_ff, rsp_connected_ff, rsp_index_error_ff;

   logic [31:0]        a_wide, b_wide, count_wide;
   logic               a_smaller;
   logic [NODE_W-1:0]  par_raddr, par_waddr, par_wdata, size_raddr, size_waddr;
   logic [SIZE_W-1:0]  size_wdata;
   logic               par_we, size_we;

   assign a_wide     = 32'(req_first_index);
   assign b_wide     = 32'(req_second_index);
   assign count_wide = 32'(count_ff);
   assign a_smaller  = (size_a_ff < size_rd_ff);

   always_comb begin
      status.in_range   = (a_wide < count_wide) && (b_wide < count_wide) &&
                          (a_wide < 32'(ELEMENTS)) && (b_wide < 32'(ELEMENTS));
      status.at_root    = (par_rd_ff == node_ff);
      status.same_root  = (root_a_ff == node_ff);
      status.query      = query_ff;
      status.clear_done = (clear_ptr_ff == NODE_W'(ELEMENTS - 1));
   end

   always_comb begin
      case (cmd)
         CMD_START:             par_raddr = NODE_W'(req_first_index);
         CMD_ASCEND, CMD_HALVE: par_raddr = par_rd_ff;
         CMD_NEXT_ROOT:         par_raddr = b_ff;
         default:               par_raddr = node_ff;
      endcase

      par_we    = 1'b0;
      par_waddr = node_ff;
      par_wdata = par_rd_ff;
      case (cmd)
         CMD_CLEAR: begin
            par_we    = 1'b1;
            par_waddr = clear_ptr_ff;
            par_wdata = clear_ptr_ff;
         end
         CMD_HALVE: begin
            // repoint the visited entry to its grandparent
            par_we = 1'b1;
         end
         CMD_LINK: begin
            par_we    = 1'b1;
            par_waddr = a_smaller ? root_a_ff : root_b_ff;
            par_wdata = a_smaller ? root_b_ff : root_a_ff;
         end
         default: par_we = 1'b0;
      endcase

      size_raddr = (cmd == CMD_SIZE_B) ? root_b_ff : root_a_ff;

      size_we    = 1'b0;
      size_waddr = a_smaller ? root_b_ff : root_a_ff;
      size_wdata = size_a_ff + size_rd_ff;
      case (cmd)
         CMD_CLEAR: begin
            size_we    = 1'b1;
            size_waddr = clear_ptr_ff;
            size_wdata = SIZE_W'(1);
         end
         CMD_LINK: size_we = 1'b1;
         default:  size_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (par_we) parent_mem[par_waddr] <= par_wdata;
      par_rd_ff <= parent_mem[par_raddr];
   end

   always_ff @(posedge clock) begin
      if (size_we) size_mem[size_waddr] <= size_wdata;
      size_rd_ff <= size_mem[size_raddr];
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_START: begin
            node_ff  <= NODE_W'(req_first_index);
            b_ff     <= NODE_W'(req_second_index);
            query_ff <= req_action;
         end
         CMD_HALVE: node_ff <= par_rd_ff;
         CMD_NEXT_ROOT: begin
            root_a_ff <= node_ff;
            node_ff   <= b_ff;
         end
         CMD_SIZE_A: root_b_ff <= node_ff;
         CMD_SIZE_B: size_a_ff <= size_rd_ff;
         default: ;
      endcase
      rsp_connected_ff   <= (cmd == CMD_ANSWER) && status.same_root;
      rsp_index_error_ff <= (cmd == CMD_REJECT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         clear_ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) count_ff <= csr_write_data;
         if (cmd == CMD_CLEAR) clear_ptr_ff <= clear_ptr_ff + NODE_W'(1);
         rsp_valid_ff <= (cmd inside {CMD_REJECT, CMD_ANSWER, CMD_LINK});
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_connected   = rsp_connected_ff;
   assign rsp_index_error = rsp_index_error_ff;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
   import wufph_pkg::*;

   localparam logic ACT_UNION = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam int   PHASES    = 8;

   typedef struct packed {
      logic connected;
      logic index_error;
   } answer_type;

   typedef enum logic { ROW_ITEM, ROW_COUNT } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         action;
      int           first;
      int           second;
      int           count;
      bit           typed;
      logic         conn;
      logic         err;
   } script_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_action;
   logic [INDEX_W-1:0]  req_first_index;
   logic [INDEX_W-1:0]  req_second_index;
   logic                csr_write_enable;
   logic [COUNT_W-1:0]  csr_write_data;
   logic                rsp_valid;
   logic                rsp_connected;
   logic                rsp_index_error;

   // word pinned by the directed table, travels with the request
   logic                typed_valid;
   answer_type          typed_answer;

   logic [INDEX_W-1:0]  parent_of [ELEMENTS_DEFAULT];
   logic [COUNT_W-1:0]  set_size [ELEMENTS_DEFAULT];
   logic [COUNT_W-1:0]  live_count;
   answer_type          pending_answers [$];
   int                  mismatch_count;
   bit                  no_gaps;

   weighted_union_find_path_halving #(
      .ELEMENTS(ELEMENTS_DEFAULT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_first_index(req_first_index),
      .req_second_index(req_second_index),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_connected(rsp_connected),
      .rsp_index_error(rsp_index_error)
   );

   always #2 clock = ~clock;

   function automatic logic [INDEX_W-1:0] find_set_root(logic [INDEX_W-1:0] node);
      logic [INDEX_W-1:0] up;
      for (int guard = 0; guard < ELEMENTS_DEFAULT; guard++) begin
         up = parent_of[node];
         if (up == node) break;
         // halve: point at grandparent, then step there
         parent_of[node] = parent_of[up];
         node = parent_of[node];
      end
      return node;
   endfunction

   function automatic answer_type apply_set_op(logic action, logic [INDEX_W-1:0] a,
                                               logic [INDEX_W-1:0] b);
      answer_type         ans;
      int                 limit;
      logic [INDEX_W-1:0] ra;
      logic [INDEX_W-1:0] rb;
      ans = '0;
      limit = (live_count > ELEMENTS_DEFAULT) ? ELEMENTS_DEFAULT : int'(live_count);
      if (int'(a) >= limit || int'(b) >= limit) begin
         ans.index_error = 1'b1;
         return ans;
      end
      ra = find_set_root(a);
      rb = find_set_root(b);
      ans.connected = (ra == rb);
      if (action == ACT_UNION && ra != rb) begin
         if (set_size[ra] < set_size[rb]) begin
            parent_of[ra] = rb;
            set_size[rb] = set_size[rb] + set_size[ra];
         end else begin
            parent_of[rb] = ra;
            set_size[ra] = set_size[ra] + set_size[rb];
         end
      end
      return ans;
   endfunction

   function automatic void note_mismatch(string what, int want, int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0d, actual %0d", what, want, got);
   endfunction

   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         for (int k = 0; k < ELEMENTS_DEFAULT; k++) begin
            parent_of[k] = k[INDEX_W-1:0];
            set_size[k] = COUNT_W'(1);
         end
         live_count = COUNT_RESET;
         pending_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               note_mismatch("unexpected word", 0, 1);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_connected !== want.connected)
                  note_mismatch("connected", int'(want.connected), int'(rsp_connected));
               if (rsp_index_error !== want.index_error)
                  note_mismatch("index_error", int'(want.index_error),
                                int'(rsp_index_error));
            end
         end
         if (csr_write_enable) live_count = csr_write_data;
         if (start && !busy) begin
            // always advance the model, even when the answer is pinned
            want = apply_set_op(req_action, req_first_index, req_second_index);
            if (typed_valid) want = typed_answer;
            pending_answers.push_back(want);
         end
      end
   end

   task automatic send_item(logic action, int a, int b, bit typed, logic conn, logic err);
      int gap;
      if (!no_gaps && $urandom_range(99) < 35) begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_action       <= action;
      req_first_index  <= a[INDEX_W-1:0];
      req_second_index <= b[INDEX_W-1:0];
      typed_valid      <= typed;
      typed_answer     <= '{connected: conn, index_error: err};
      do @(posedge clock); while (busy);
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_count(int value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[COUNT_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   script_row_type script [27] = '{
      '{ROW_ITEM,  ACT_QUERY,    0,    0,    0, 1, 1'b1, 1'b0},
      '{ROW_ITEM,  ACT_QUERY,    0, 1023,    0, 1, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_UNION,    0, 1023,    0, 1, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_QUERY, 1023,    0,    0, 1, 1'b1, 1'b0},
      '{ROW_ITEM,  ACT_UNION, 1023,    0,    0, 1, 1'b1, 1'b0},
      '{ROW_ITEM,  ACT_UNION,    1,    2,    0, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_UNION,    3,    4,    0, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_UNION,    1,    3,    0, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_UNION,    5,    4,    0, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_QUERY,    2,    5,    0, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_UNION, 1000,   10,    0, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_UNION, 1000,   11,    0, 0, 1'b0, 1'b0},
      '{ROW_COUNT, ACT_QUERY,    0,    0,   16, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_QUERY,   10,   11,    0, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_QUERY,   15,   16,    0, 1, 1'b0, 1'b1},
      '{ROW_ITEM,  ACT_UNION,   16,   15,    0, 1, 1'b0, 1'b1},
      '{ROW_ITEM,  ACT_UNION, 1023, 1023,    0, 1, 1'b0, 1'b1},
      '{ROW_COUNT, ACT_QUERY,    0,    0,    0, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_QUERY,    0,    0,    0, 1, 1'b0, 1'b1},
      '{ROW_COUNT, ACT_QUERY,    0,    0, 2047, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_QUERY, 1023, 1023,    0, 1, 1'b1, 1'b0},
      '{ROW_ITEM,  ACT_UNION, 1023,  512,    0, 0, 1'b0, 1'b0},
      '{ROW_COUNT, ACT_QUERY,    0,    0,    1, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_QUERY,    0,    0,    0, 1, 1'b1, 1'b0},
      '{ROW_ITEM,  ACT_UNION,    0,    1,    0, 1, 1'b0, 1'b1},
      '{ROW_COUNT, ACT_QUERY,    0,    0, 1024, 0, 1'b0, 1'b0},
      '{ROW_ITEM,  ACT_QUERY,  512,    0,    0, 0, 1'b0, 1'b0}
   };

   int phase_count [PHASES] = '{1024, 2047, 40, 1, 0, 300, 0, 1024};
   int phase_items [PHASES] = '{300, 250, 300, 60, 40, 250, 250, 300};

   initial begin : stimulus
      int limit;
      int count;
      int a;
      int b;
      clock            = 1'b0;
      mismatch_count   = 0;
      no_gaps          = 1'b0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= ACT_UNION;
      req_first_index  <= '0;
      req_second_index <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      typed_valid      <= 1'b0;
      typed_answer     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // hold off until the store sweep after reset is done
      drain();

      foreach (script[i]) begin
         if (script[i].kind == ROW_COUNT)
            write_count(script[i].count);
         else
            send_item(script[i].action, script[i].first, script[i].second,
                      script[i].typed, script[i].conn, script[i].err);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         count = phase_count[ph];
         if (ph == 6) count = $urandom_range(2, 1023);
         write_count(count);
         limit = (count > ELEMENTS_DEFAULT) ? ELEMENTS_DEFAULT : count;
         no_gaps = (ph == 2);
         for (int n = 0; n < phase_items[ph]; n++) begin
            // mostly in range, with an occasional stray index anywhere
            if (limit == 0 || $urandom_range(9) == 0) a = $urandom_range(1023);
            else a = $urandom_range(limit - 1);
            if (limit == 0 || $urandom_range(9) == 0) b = $urandom_range(1023);
            else b = $urandom_range(limit - 1);
            send_item(1'($urandom_range(1)), a, b, 1'b0, 1'b0, 1'b0);
         end
      end
      no_gaps = 1'b0;

      drain();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
